// ----- rtl/sssp_pkg.sv -----
// Shared types and constants of the single-source shortest paths unit.
package sssp_pkg;

  localparam int VtxW  = 6;
  localparam int CntW  = 7;
  localparam int DistW = 30;
  localparam int WgtW  = 16;

  localparam logic [DistW-1:0] Unreached = 30'd1000000000;

  // command opcodes
  localparam logic [1:0] OpAddEdge = 2'd0;
  localparam logic [1:0] OpRun     = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;

  // result status codes
  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatNegWeight = 2'd1;
  localparam logic [1:0] StatBadVertex = 2'd2;
  localparam logic [1:0] StatStoreFull = 2'd3;

  // configuration register index
  localparam logic RegVertexCount = 1'b0;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [VtxW-1:0] edge_from;
    logic [VtxW-1:0] edge_to;
    logic [WgtW-1:0] edge_weight;
    logic [VtxW-1:0] source_vertex;
  } cmd_t;

  typedef struct packed {
    logic [VtxW-1:0]  vertex_index;
    logic [DistW-1:0] distance;
    logic [VtxW-1:0]  predecessor;
    logic             has_predecessor;
    logic [1:0]       status;
    logic             last_result;
  } result_t;

  typedef struct packed {
    logic [VtxW-1:0] from;
    logic [VtxW-1:0] to;
    logic [WgtW-1:0] weight;
  } edge_t;

endpackage

// ----- rtl/sssp_edge_mem.sv -----
// Edge store: one write port, one registered read port.
module sssp_edge_mem #(
  parameter int Depth = 1024,
  parameter int Aw    = 10
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [Aw-1:0]       waddr_i,
  input  sssp_pkg::edge_t     wdata_i,
  input  logic [Aw-1:0]       raddr_i,
  output sssp_pkg::edge_t     rdata_o
);

  sssp_pkg::edge_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/single_source_shortest_paths_unit.sv -----
// Single-source shortest paths unit: edge store, run sequencer and result stream.
//
// Commands are taken when start is high and busy is low. An add-edge or clear command
// completes without busy rising; an error result is registered and appears in the cycle
// after its command. A run first clears the n-entry distance and predecessor tables, then
// repeats rounds: a scan of all n vertices through the distance memory read port picks the
// next vertex, and a walk over the E stored edges relaxes the edges leaving it. The results
// then follow on consecutive cycles, one per vertex, each shown for exactly one cycle with
// result_valid_o; the receiver must take them as they come.
module single_source_shortest_paths_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sssp_pkg::cmd_t    cmd_i,
  output logic              result_valid_o,
  output sssp_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int Aw  = $clog2(MAX_VERTICES);
  localparam int Ew  = $clog2(MAX_EDGES + 1);
  localparam int Eaw = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int Cw  = sssp_pkg::CntW;
  localparam int Vw  = sssp_pkg::VtxW;
  localparam int Dw  = sssp_pkg::DistW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StInit = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StERd  = 3'd3;
  localparam logic [2:0] StEChk = 3'd4;
  localparam logic [2:0] StECmp = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  // configuration register
  logic [Cw-1:0] vcount_q;
  logic [Cw-1:0] n_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 7'd64;
    end else if (psel && penable && pwrite && (paddr[2] == sssp_pkg::RegVertexCount)) begin
      vcount_q <= pwdata[Cw-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sssp_pkg::RegVertexCount) ? {25'd0, vcount_q} : 32'd0;

  // effective vertex count, clamped to 1..MAX_VERTICES
  always_comb begin
    if (vcount_q == '0) begin
      n_w = 7'd1;
    end else if (vcount_q > Cw'(MAX_VERTICES)) begin
      n_w = Cw'(MAX_VERTICES);
    end else begin
      n_w = vcount_q;
    end
  end

  // state
  logic [2:0]        state_q, state_d;
  logic [Ew-1:0]     etotal_q, etotal_d;
  logic              neg_q, neg_d;
  logic [Ew-1:0]     e_q, e_d;
  logic [Cw-1:0]     idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [Cw-1:0]     pidx_q, pidx_d;
  logic              found_q, found_d;
  logic [Vw-1:0]     best_q, best_d;
  logic [Dw-1:0]     bestd_q, bestd_d;
  logic [Vw-1:0]     src_q, src_d;
  logic [MAX_VERTICES-1:0] settled_q, settled_d;
  logic              rv_q, rv_d;
  sssp_pkg::result_t res_q, res_d;

  // memories and their ports
  logic [Dw-1:0]   dist_mem [MAX_VERTICES];
  logic [Vw:0]     pred_mem [MAX_VERTICES];
  logic [Dw-1:0]   dist_rd_q;
  logic [Vw:0]     pred_rd_q;
  logic [Aw-1:0]   rd_addr;
  logic            vwe;
  logic [Aw-1:0]   vwaddr;
  logic [Dw-1:0]   vwdist;
  logic [Vw:0]     vwpred;
  logic            ewe;
  sssp_pkg::edge_t ewdata, erd;
  logic [Dw-1:0]   cand;
  logic            ematch;
  logic            elast;

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      dist_mem[vwaddr] <= vwdist;
      pred_mem[vwaddr] <= vwpred;
    end
    dist_rd_q <= dist_mem[rd_addr];
    pred_rd_q <= pred_mem[rd_addr];
  end

  sssp_edge_mem #(
    .Depth (MAX_EDGES),
    .Aw    (Eaw)
  ) u_edges (
    .clk_i   (clk_i),
    .we_i    (ewe),
    .waddr_i (etotal_q[Eaw-1:0]),
    .wdata_i (ewdata),
    .raddr_i (e_q[Eaw-1:0]),
    .rdata_o (erd)
  );

  assign ewdata = '{from: cmd_i.edge_from, to: cmd_i.edge_to, weight: cmd_i.edge_weight};
  assign cand   = bestd_q + Dw'(erd.weight[14:0]);
  assign ematch = (erd.from == best_q) && ({1'b0, erd.to} < n_w);
  assign elast  = ((e_q + Ew'(1)) >= etotal_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    etotal_d  = etotal_q;
    neg_d     = neg_q;
    e_d       = e_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    found_d   = found_q;
    best_d    = best_q;
    bestd_d   = bestd_q;
    src_d     = src_q;
    settled_d = settled_q;
    rv_d      = 1'b0;
    res_d     = res_q;
    rd_addr   = idx_q[Aw-1:0];
    vwe       = 1'b0;
    vwaddr    = idx_q[Aw-1:0];
    vwdist    = sssp_pkg::Unreached;
    vwpred    = '0;
    ewe       = 1'b0;

    case (state_q)
      StIdle: begin
        if (start) begin
          res_d = '{default: '0};
          res_d.last_result = 1'b1;
          case (cmd_i.opcode)
            sssp_pkg::OpAddEdge: begin
              if (({1'b0, cmd_i.edge_from} >= n_w) || ({1'b0, cmd_i.edge_to} >= n_w)) begin
                rv_d = 1'b1;
                res_d.status = sssp_pkg::StatBadVertex;
              end else if (etotal_q >= Ew'(MAX_EDGES)) begin
                rv_d = 1'b1;
                res_d.status = sssp_pkg::StatStoreFull;
              end else begin
                ewe      = 1'b1;
                etotal_d = etotal_q + Ew'(1);
                neg_d    = neg_q | cmd_i.edge_weight[15];
              end
            end
            sssp_pkg::OpRun: begin
              if ({1'b0, cmd_i.source_vertex} >= n_w) begin
                rv_d = 1'b1;
                res_d.status = sssp_pkg::StatBadVertex;
              end else if (neg_q) begin
                rv_d = 1'b1;
                res_d.status = sssp_pkg::StatNegWeight;
              end else begin
                src_d     = cmd_i.source_vertex;
                idx_d     = '0;
                settled_d = '0;
                state_d   = StInit;
              end
            end
            sssp_pkg::OpClear: begin
              etotal_d = '0;
              neg_d    = 1'b0;
            end
            default: ;
          endcase
        end
      end

      // clear the tables for the run
      StInit: begin
        vwe    = 1'b1;
        vwdist = (idx_q[Vw-1:0] == src_q) ? '0 : sssp_pkg::Unreached;
        if (idx_q + Cw'(1) >= n_w) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = StScan;
        end else begin
          idx_d = idx_q + Cw'(1);
        end
      end

      // pick the unsettled vertex of least finite distance, ties to the larger index
      StScan: begin
        if (idx_q < n_w) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          idx_d  = idx_q + Cw'(1);
        end
        if (pend_q && !settled_q[pidx_q[Aw-1:0]] && (dist_rd_q < sssp_pkg::Unreached) &&
            (!found_q || (dist_rd_q <= bestd_q))) begin
          found_d = 1'b1;
          best_d  = pidx_q[Vw-1:0];
          bestd_d = dist_rd_q;
        end
        if ((idx_q >= n_w) && !pend_q) begin
          idx_d = '0;
          if (found_q) begin
            settled_d[best_q[Aw-1:0]] = 1'b1;
            e_d     = '0;
            found_d = 1'b0;
            state_d = (etotal_q == '0) ? StScan : StERd;
          end else begin
            state_d = StOut;
          end
        end
      end

      StERd: begin
        state_d = StEChk;
      end

      // test the edge and fetch its head's distance
      StEChk: begin
        rd_addr = erd.to[Aw-1:0];
        if (ematch) begin
          state_d = StECmp;
        end else begin
          e_d     = e_q + Ew'(1);
          state_d = elast ? StScan : StERd;
        end
      end

      // relax on strict improvement
      StECmp: begin
        vwaddr = erd.to[Aw-1:0];
        vwdist = cand;
        vwpred = {1'b1, best_q};
        vwe    = (cand < dist_rd_q);
        e_d    = e_q + Ew'(1);
        state_d = elast ? StScan : StERd;
      end

      // stream one result per vertex
      StOut: begin
        if (idx_q < n_w) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          idx_d  = idx_q + Cw'(1);
        end
        if (pend_q) begin
          rv_d = 1'b1;
          res_d.vertex_index    = pidx_q[Vw-1:0];
          res_d.distance        = dist_rd_q;
          res_d.has_predecessor = pred_rd_q[Vw];
          res_d.predecessor     = pred_rd_q[Vw] ? pred_rd_q[Vw-1:0] : '0;
          res_d.status          = sssp_pkg::StatOk;
          res_d.last_result     = ((pidx_q + Cw'(1)) == n_w);
        end
        if ((idx_q >= n_w) && !pend_q) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      etotal_q  <= '0;
      neg_q     <= 1'b0;
      e_q       <= '0;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      pidx_q    <= '0;
      found_q   <= 1'b0;
      best_q    <= '0;
      bestd_q   <= '0;
      src_q     <= '0;
      settled_q <= '0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      etotal_q  <= etotal_d;
      neg_q     <= neg_d;
      e_q       <= e_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      pidx_q    <= pidx_d;
      found_q   <= found_d;
      best_q    <= best_d;
      bestd_q   <= bestd_d;
      src_q     <= src_d;
      settled_q <= settled_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  // checks
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status != sssp_pkg::StatOk)) |-> result_o.last_result)
    else $error("error result not marked last");

  a_pred_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.has_predecessor) |-> (result_o.distance < sssp_pkg::Unreached))
    else $error("predecessor on unreached vertex");

  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    etotal_q <= Ew'(MAX_EDGES))
    else $error("edge count beyond store");

endmodule

// ----- test/tb.sv -----
// Testbench for the single-source shortest paths unit: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;

  localparam int MaxVtx    = 64;
  localparam int MaxEdges  = 1024;
  localparam int IdleLimit = 1000000;
  localparam int Vw        = sssp_pkg::VtxW;
  localparam int Ww        = sssp_pkg::WgtW;
  localparam int Dw        = sssp_pkg::DistW;
  localparam int Cw        = sssp_pkg::CntW;
  localparam logic [1:0] OpNop = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  sssp_pkg::cmd_t    cmd_i = '0;
  logic              result_valid_o;
  sssp_pkg::result_t result_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  single_source_shortest_paths_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [Vw-1:0] st_from [MaxEdges];
  logic [Vw-1:0] st_to   [MaxEdges];
  logic [Ww-1:0] st_wgt  [MaxEdges];
  int            edge_cnt = 0;
  bit            neg_loaded = 0;
  int            vcount_reg = 64;

  sssp_pkg::result_t pending_results[$];
  int      fail_cnt = 0;
  int      burst_left = 0;

  function automatic int eff_count();
    if (vcount_reg < 1) return 1;
    if (vcount_reg > MaxVtx) return MaxVtx;
    return vcount_reg;
  endfunction

  function automatic sssp_pkg::result_t err_result(logic [1:0] code);
    sssp_pkg::result_t r;
    r = '0;
    r.status = code;
    r.last_result = 1'b1;
    return r;
  endfunction

  // append one expected result
  function automatic void queue_expected(input sssp_pkg::result_t r);
    pending_results = {pending_results, r};
  endfunction

  // dijkstra over the stored edges; ties go to the larger index
  task automatic predict_paths(input sssp_pkg::cmd_t c);
    int n, best, cand, v;
    bit found;
    int dist_v [MaxVtx];
    int pred [MaxVtx];
    bit pvld [MaxVtx];
    bit done [MaxVtx];
    sssp_pkg::result_t r;
    n = eff_count();
    case (c.opcode)
      sssp_pkg::OpAddEdge: begin
        if (c.edge_from >= n || c.edge_to >= n)
          queue_expected(err_result(sssp_pkg::StatBadVertex));
        else if (edge_cnt >= MaxEdges) queue_expected(err_result(sssp_pkg::StatStoreFull));
        else begin
          st_from[edge_cnt] = c.edge_from;
          st_to[edge_cnt]   = c.edge_to;
          st_wgt[edge_cnt]  = c.edge_weight;
          if (c.edge_weight[Ww-1]) neg_loaded = 1;
          edge_cnt++;
        end
      end
      sssp_pkg::OpClear: begin
        edge_cnt = 0;
        neg_loaded = 0;
      end
      sssp_pkg::OpRun: begin
        if (c.source_vertex >= n) queue_expected(err_result(sssp_pkg::StatBadVertex));
        else if (neg_loaded) queue_expected(err_result(sssp_pkg::StatNegWeight));
        else begin
          for (int i = 0; i < MaxVtx; i++) begin
            dist_v[i] = int'(sssp_pkg::Unreached); pred[i] = 0; pvld[i] = 0; done[i] = 0;
          end
          dist_v[c.source_vertex] = 0;
          for (int rd = 0; rd < n; rd++) begin
            found = 0; best = 0;
            for (int i = 0; i < n; i++) begin
              if (done[i] || dist_v[i] >= int'(sssp_pkg::Unreached)) continue;
              if (!found || dist_v[i] <= dist_v[best]) begin
                best = i; found = 1;
              end
            end
            if (!found) break;
            done[best] = 1;
            for (int e = 0; e < edge_cnt; e++) begin
              v = int'(st_to[e]);
              if (st_from[e] != best || v >= n) continue;
              cand = dist_v[best] + int'(st_wgt[e][Ww-2:0]);
              if (cand < dist_v[v]) begin
                dist_v[v] = cand; pred[v] = best; pvld[v] = 1;
              end
            end
          end
          for (int i = 0; i < n; i++) begin
            r.vertex_index    = Vw'(i);
            r.distance        = Dw'(dist_v[i]);
            r.predecessor     = pvld[i] ? Vw'(pred[i]) : '0;
            r.has_predecessor = pvld[i];
            r.status          = sssp_pkg::StatOk;
            r.last_result     = (i == n - 1);
            queue_expected(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // drive one command; sender runs in bursts with random gaps
  task automatic issue_cmd(input sssp_pkg::cmd_t c);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = $urandom_range(10, 30);
      end else begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 8);
      end
      if (gap > 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start = 1'b1;
    cmd_i = c;
    do @(posedge clk_i); while (busy);
    predict_paths(c);
  endtask

  // let the unit drain before touching the register
  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write followed by a read-back
  task automatic write_vcount(input int val);
    wait_idle();
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = {sssp_pkg::RegVertexCount, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[Cw-1:0] !== val[Cw-1:0]) begin
      $display("%0t: vertex_count read expected %0d actual %0d", $time, val[Cw-1:0],
               prdata[Cw-1:0]);
      fail_cnt++;
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
    vcount_reg = val & 32'h7F;
  endtask

  // result checker and watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result_o);
          fail_cnt++;
        end else begin
          sssp_pkg::result_t x;
          x = pending_results.pop_front();
          if (result_o.vertex_index !== x.vertex_index) begin
            $display("%0t: vertex_index expected %0d actual %0d", $time, x.vertex_index,
                     result_o.vertex_index); fail_cnt++;
          end
          if (result_o.distance !== x.distance) begin
            $display("%0t: distance expected %0d actual %0d", $time, x.distance,
                     result_o.distance); fail_cnt++;
          end
          if (result_o.predecessor !== x.predecessor) begin
            $display("%0t: predecessor expected %0d actual %0d", $time, x.predecessor,
                     result_o.predecessor); fail_cnt++;
          end
          if (result_o.has_predecessor !== x.has_predecessor) begin
            $display("%0t: has_predecessor expected %0b actual %0b", $time,
                     x.has_predecessor, result_o.has_predecessor); fail_cnt++;
          end
          if (result_o.status !== x.status) begin
            $display("%0t: status expected %0d actual %0d", $time, x.status,
                     result_o.status); fail_cnt++;
          end
          if (result_o.last_result !== x.last_result) begin
            $display("%0t: last_result expected %0b actual %0b", $time, x.last_result,
                     result_o.last_result); fail_cnt++;
          end
        end
      end
    end
  end

  // directed rows: optional register write, command, optional typed error status
  typedef struct {
    int         cfg;
    logic [1:0] op;
    int         from;
    int         to;
    int         wgt;
    int         src;
    bit         typed;
    logic [1:0] code;
  } row_t;

  row_t directed_rows[] = '{
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,      0,  0, sssp_pkg::StatOk},
    '{5,   sssp_pkg::OpAddEdge, 0,  1, 3,      0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpAddEdge, 0,  2, 3,      0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpAddEdge, 1,  3, 1,      0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpAddEdge, 2,  3, 1,      0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpAddEdge, 3,  4, 32767,  0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,      0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,      4,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpAddEdge, 5,  0, 1,      0,  1, sssp_pkg::StatBadVertex},
    '{-1,  sssp_pkg::OpAddEdge, 0, 63, 1,      0,  1, sssp_pkg::StatBadVertex},
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,     63,  1, sssp_pkg::StatBadVertex},
    '{-1,  OpNop,              63, 63, 65535, 63,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpAddEdge, 4,  0, 32768,  0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,      1,  1, sssp_pkg::StatNegWeight},
    '{-1,  sssp_pkg::OpClear,   0,  0, 0,      0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,      1,  0, sssp_pkg::StatOk},
    '{0,   sssp_pkg::OpRun,     0,  0, 0,      0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpAddEdge, 0,  0, 0,      0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,      0,  0, sssp_pkg::StatOk},
    '{127, sssp_pkg::OpAddEdge, 63, 62, 32767, 0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,     63,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpAddEdge, 63, 0, 65535,  0,  0, sssp_pkg::StatOk},
    '{-1,  sssp_pkg::OpRun,     0,  0, 0,      0,  1, sssp_pkg::StatNegWeight},
    '{-1,  sssp_pkg::OpClear,   0,  0, 0,      0,  0, sssp_pkg::StatOk}
  };

  function automatic sssp_pkg::cmd_t make_cmd(logic [1:0] op, int f, int t, int w, int s);
    sssp_pkg::cmd_t c;
    c.opcode = op; c.edge_from = Vw'(f); c.edge_to = Vw'(t); c.edge_weight = Ww'(w);
    c.source_vertex = Vw'(s);
    return c;
  endfunction

  initial begin
    int n, items, k;
    sssp_pkg::cmd_t c;
    int cfg_choices[] = '{64, 17, 5, 33, 1, 127, 2};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg >= 0) write_vcount(directed_rows[i].cfg);
      issue_cmd(make_cmd(directed_rows[i].op, directed_rows[i].from, directed_rows[i].to,
                         directed_rows[i].wgt, directed_rows[i].src));
      if (directed_rows[i].typed) pending_results[$] = err_result(directed_rows[i].code);
    end

    // random phases: load a graph, then run it from a few sources
    items = 0;
    k = 0;
    while (items < 76) begin
      write_vcount(cfg_choices[k % cfg_choices.size()]);
      k++;
      n = eff_count();
      repeat (2) begin
        issue_cmd(make_cmd(sssp_pkg::OpClear, $urandom, $urandom, $urandom, $urandom));
        items++;
        repeat ($urandom_range(0, 24)) begin
          c = make_cmd(sssp_pkg::OpAddEdge, $urandom_range(0, n - 1),
                       $urandom_range(0, n - 1),
                       ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 32767)),
                       $urandom);
          case ($urandom_range(0, 19))
            0: c.edge_weight[Ww-1] = 1'b1;
            1: c.edge_from = Vw'($urandom);
            2: c.edge_to = Vw'($urandom);
            3: c.opcode = OpNop;
            default: ;
          endcase
          issue_cmd(c);
          if (c.opcode != OpNop) items++;
        end
        repeat ($urandom_range(1, 3)) begin
          c = make_cmd(sssp_pkg::OpRun, $urandom, $urandom, $urandom,
                       $urandom_range(0, n - 1));
          if ($urandom_range(0, 7) == 0) c.source_vertex = Vw'($urandom);
          issue_cmd(c);
          items++;
        end
      end
    end

    // drain
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sssp_pkg.sv
rtl/sssp_edge_mem.sv
rtl/single_source_shortest_paths_unit.sv
test/tb.sv
